/* rtl/xsfb_pkg.sv */
// ============================================================================
// xsfb_pkg: shared types and codes of the XOR sprite framebuffer
// Command codes and the control/status bundles between controller and datapath.
// ============================================================================
package xsfb_pkg;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_DRAW  = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    // controller -> datapath strobes, at most one high in one cycle
    typedef struct packed {
        logic ld_req;     // capture the request payload
        logic step_mod;   // reduce x and y by the display size
        logic step_wrap;  // add row index, wrap or range-check the row
        logic step_addr;  // byte indices, shifted sprite halves
        logic rd_first;   // read the left byte
        logic wr_first;   // xor the left byte back
        logic rd_second;  // read the spill byte
        logic wr_second;  // xor the spill byte back
        logic rd_byte;    // read the addressed byte
        logic cap_byte;   // capture read data
        logic sweep;      // write zero at the sweep address
        logic ld_out;     // load the result register
    } t_dp_ctl;

    // datapath -> controller status
    typedef struct packed {
        logic row_ok;     // target row lies on the display
        logic drop;       // spill byte clipped away
        logic sweep_last; // sweep address at the last store byte
        logic out_free;   // result register can take a new result
    } t_dp_stat;

endpackage

/* rtl/xsfb_if.sv */
// ============================================================================
// xsfb_if: channel interfaces of the XOR sprite framebuffer
// Request, response and configuration channels with valid/ready transfer.
// ============================================================================
interface xsfb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] row_index;
    logic [7:0] sprite_byte;
    logic [7:0] read_addr;

    modport source (output valid, cmd, pos_x, pos_y, row_index, sprite_byte, read_addr,
                    input ready);
    modport sink   (input valid, cmd, pos_x, pos_y, row_index, sprite_byte, read_addr,
                    output ready);
endinterface

interface xsfb_rsp_if;
    logic       valid;
    logic       ready;
    logic       collision;
    logic [7:0] read_data;

    modport source (output valid, collision, read_data, input ready);
    modport sink   (input valid, collision, read_data, output ready);
endinterface

interface xsfb_cfg_if;
    logic valid;
    logic ready;
    logic clip_mode;

    modport source (output valid, clip_mode, input ready);
    modport sink   (input valid, clip_mode, output ready);
endinterface

/* rtl/xsfb_ram.sv */
// ============================================================================
// xsfb_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on collision).
// ============================================================================
module xsfb_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 256,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/xsfb_ctrl.sv */
// ============================================================================
// xsfb_ctrl: command sequencer of the XOR sprite framebuffer
// Walks each command through the datapath and the store port.
// ============================================================================
module xsfb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  xsfb_pkg::t_cmd     i_req_cmd,
    input  xsfb_pkg::t_dp_stat i_stat,
    output logic               o_req_ready,
    output xsfb_pkg::t_dp_ctl  o_ctl
);
    import xsfb_pkg::*;

    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MOD   = 4'd2;
    localparam logic [3:0] S_WRAP  = 4'd3;
    localparam logic [3:0] S_ADDR  = 4'd4;
    localparam logic [3:0] S_RD1   = 4'd5;
    localparam logic [3:0] S_WR1   = 4'd6;
    localparam logic [3:0] S_RD2   = 4'd7;
    localparam logic [3:0] S_WR2   = 4'd8;
    localparam logic [3:0] S_RDB   = 4'd9;
    localparam logic [3:0] S_RDW   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_rsp, n_rsp;   // sweep ends in a response (clear command)
    logic       accept;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = o_req_ready && i_req_valid;

    always_comb begin
        n_state = r_state;
        n_rsp   = r_rsp;
        o_ctl   = '0;
        unique case (r_state)
            S_SWEEP: begin
                o_ctl.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = r_rsp ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_ctl.ld_req = 1'b1;
                    unique case (i_req_cmd)
                        CMD_CLEAR: begin
                            n_state = S_SWEEP;
                            n_rsp   = 1'b1;
                        end
                        CMD_DRAW: n_state = S_MOD;
                        CMD_READ: n_state = S_RDB;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_MOD: begin
                o_ctl.step_mod = 1'b1;
                n_state        = S_WRAP;
            end
            S_WRAP: begin
                o_ctl.step_wrap = 1'b1;
                n_state         = S_ADDR;
            end
            S_ADDR: begin
                o_ctl.step_addr = 1'b1;
                n_state         = i_stat.row_ok ? S_RD1 : S_DONE;
            end
            S_RD1: begin
                o_ctl.rd_first = 1'b1;
                n_state        = S_WR1;
            end
            S_WR1: begin
                o_ctl.wr_first = 1'b1;
                n_state        = i_stat.drop ? S_DONE : S_RD2;
            end
            S_RD2: begin
                o_ctl.rd_second = 1'b1;
                n_state         = S_WR2;
            end
            S_WR2: begin
                o_ctl.wr_second = 1'b1;
                n_state         = S_DONE;
            end
            S_RDB: begin
                o_ctl.rd_byte = 1'b1;
                n_state       = S_RDW;
            end
            S_RDW: begin
                o_ctl.cap_byte = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_ctl.ld_out = 1'b1;
                    n_rsp        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_rsp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rsp   <= n_rsp;
        end
    end

endmodule

/* rtl/xsfb_dp.sv */
// ============================================================================
// xsfb_dp: datapath of the XOR sprite framebuffer
// Coordinate reduction, byte addressing, XOR/collision, sweep and result regs.
// ============================================================================
module xsfb_dp #(
    parameter int  DISP_WIDTH  = 64,
    parameter int  DISP_HEIGHT = 32,
    localparam int ROW_BYTES   = DISP_WIDTH / 8,
    localparam int STORE_BYTES = ROW_BYTES * DISP_HEIGHT,
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xsfb_pkg::t_dp_ctl  i_ctl,
    output xsfb_pkg::t_dp_stat o_stat,
    // request payload
    input  logic [7:0]         i_pos_x,
    input  logic [7:0]         i_pos_y,
    input  logic [3:0]         i_row_index,
    input  logic [7:0]         i_sprite_byte,
    input  logic [7:0]         i_read_addr,
    // configuration
    input  logic               i_cfg_valid,
    input  logic               i_cfg_clip_mode,
    // store port
    output logic               o_ram_we,
    output logic [AW-1:0]      o_ram_waddr,
    output logic [7:0]         o_ram_wdata,
    output logic [AW-1:0]      o_ram_raddr,
    input  logic [7:0]         i_ram_rdata,
    // response
    input  logic               i_rsp_ready,
    output logic               o_rsp_valid,
    output logic               o_rsp_collision,
    output logic [7:0]         o_rsp_read_data
);
    import xsfb_pkg::*;

    localparam int IW  = AW + 1;
    localparam int XW  = $clog2(DISP_WIDTH);
    localparam int YMW = (DISP_HEIGHT > 1) ? $clog2(DISP_HEIGHT) : 1;
    localparam int YSW = $clog2(DISP_HEIGHT + 16);

    // request payload
    logic [7:0]       r_pos_x;
    logic [7:0]       r_pos_y;
    logic [3:0]       r_row_index;
    logic [7:0]       r_sprite;
    logic [7:0]       r_read_addr;

    logic [XW-1:0]    r_xm;
    logic [YMW-1:0]   r_ym;
    logic [YSW-1:0]   r_y;
    logic             r_row_ok;
    logic [IW-1:0]    r_first;
    logic [IW-1:0]    r_second;
    logic             r_drop;
    logic [7:0]       r_left;
    logic [7:0]       r_right;
    logic [7:0]       r_rbyte;
    logic             r_acc;
    logic             r_clip;
    logic [AW-1:0]    r_sweep_cnt;
    logic             r_out_valid;
    logic             r_out_coll;
    logic [7:0]       r_out_data;

    logic [15:0]      xmod_t;
    logic [15:0]      ymod_t;
    logic [15:0]      ywrap_t;
    logic [YSW-1:0]   ysum;
    logic [IW-1:0]    base;
    logic [IW-1:0]    first;
    logic [XW:0]      x_end;
    logic             spill;
    logic [15:0]      shifted;
    logic             first_ok;
    logic             second_ok;
    logic             byte_ok;
    logic             wr_ok;
    logic [7:0]       wr_bits;
    logic             hit;

    // x mod width and y mod height: restoring reduction by shifted multiples
    always_comb begin
        xmod_t = 16'(r_pos_x);
        for (int k = 7; k >= 0; k--) begin
            if (xmod_t >= (16'(DISP_WIDTH) << k)) begin
                xmod_t = xmod_t - (16'(DISP_WIDTH) << k);
            end
        end
    end

    always_comb begin
        ymod_t = 16'(r_pos_y);
        for (int k = 7; k >= 0; k--) begin
            if (ymod_t >= (16'(DISP_HEIGHT) << k)) begin
                ymod_t = ymod_t - (16'(DISP_HEIGHT) << k);
            end
        end
    end

    // row sum stays below height + 15, so four steps cover the wrap
    assign ysum = YSW'(r_ym) + YSW'(r_row_index);

    always_comb begin
        ywrap_t = 16'(ysum);
        for (int k = 3; k >= 0; k--) begin
            if (ywrap_t >= (16'(DISP_HEIGHT) << k)) begin
                ywrap_t = ywrap_t - (16'(DISP_HEIGHT) << k);
            end
        end
    end

    assign base    = IW'(r_y) * IW'(ROW_BYTES);
    assign first   = base + IW'(r_xm >> 3);
    assign x_end   = (XW + 1)'(r_xm) + (XW + 1)'(8);
    assign spill   = x_end > (XW + 1)'(DISP_WIDTH);
    assign shifted = {r_sprite, 8'h00} >> r_xm[2:0];

    assign first_ok  = r_first  < IW'(STORE_BYTES);
    assign second_ok = r_second < IW'(STORE_BYTES);
    assign byte_ok   = 16'(r_read_addr) < 16'(STORE_BYTES);

    assign wr_bits = i_ctl.wr_second ? r_right : r_left;
    assign wr_ok   = i_ctl.wr_second ? second_ok : first_ok;
    assign hit     = wr_ok && ((i_ram_rdata & wr_bits) != 8'h00);

    // store port
    always_comb begin
        o_ram_raddr = r_first[AW-1:0];
        if (i_ctl.rd_byte) begin
            o_ram_raddr = AW'(r_read_addr);
        end else if (i_ctl.rd_second) begin
            o_ram_raddr = r_second[AW-1:0];
        end
    end

    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_first[AW-1:0];
        o_ram_wdata = i_ram_rdata ^ wr_bits;
        if (i_ctl.sweep) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_sweep_cnt;
            o_ram_wdata = 8'h00;
        end else if (i_ctl.wr_first || i_ctl.wr_second) begin
            o_ram_we    = wr_ok;
            o_ram_waddr = i_ctl.wr_second ? r_second[AW-1:0] : r_first[AW-1:0];
        end
    end

    // payload and address registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_req) begin
            r_pos_x     <= i_pos_x;
            r_pos_y     <= i_pos_y;
            r_row_index <= i_row_index;
            r_sprite    <= i_sprite_byte;
            r_read_addr <= i_read_addr;
            r_rbyte     <= 8'h00;
        end
        if (i_ctl.step_mod) begin
            r_xm <= XW'(xmod_t);
            r_ym <= YMW'(ymod_t);
        end
        if (i_ctl.step_wrap) begin
            r_y      <= r_clip ? ysum : YSW'(ywrap_t);
            r_row_ok <= !r_clip || (ysum < YSW'(DISP_HEIGHT));
        end
        if (i_ctl.step_addr) begin
            r_first  <= first;
            r_second <= spill ? base : first + IW'(1);
            r_drop   <= spill && r_clip;
            r_left   <= shifted[15:8];
            r_right  <= shifted[7:0];
        end
        if (i_ctl.cap_byte) begin
            r_rbyte <= byte_ok ? i_ram_rdata : 8'h00;
        end
        if (i_ctl.ld_out) begin
            r_out_coll <= r_acc;
            r_out_data <= r_rbyte;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 1'b0;
            r_clip      <= 1'b0;
            r_sweep_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_clip <= i_cfg_clip_mode;
            end
            if (i_ctl.step_mod && (r_row_index == 4'd0)) begin
                r_acc <= 1'b0;
            end else if (i_ctl.wr_first || i_ctl.wr_second) begin
                r_acc <= r_acc | hit;
            end
            if (i_ctl.sweep && !o_stat.sweep_last) begin
                r_sweep_cnt <= r_sweep_cnt + AW'(1);
            end else begin
                r_sweep_cnt <= '0;
            end
            if (i_ctl.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.row_ok     = r_row_ok;
    assign o_stat.drop       = r_drop;
    assign o_stat.sweep_last = (r_sweep_cnt == AW'(STORE_BYTES - 1));
    assign o_stat.out_free   = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid     = r_out_valid;
    assign o_rsp_collision = r_out_coll;
    assign o_rsp_read_data = r_out_data;

endmodule

/* rtl/xor_sprite_framebuffer.sv */
// ============================================================================
// xor_sprite_framebuffer: 1-bpp display store with XOR sprite drawing
// Top level: sequencer, datapath and the byte-wide display store.
// ============================================================================
// The display is DISP_WIDTH x DISP_HEIGHT pixels, one bit each, packed
// DISP_WIDTH/8 bytes per row with the leftmost pixel in the byte MSB. A draw
// command XORs one 8-pixel sprite row at (x mod width, (y mod height) + row)
// and reports the collision flag gathered over the sprite so far (row 0
// restarts it); a read returns one store byte, zero past the end of the store;
// a clear zeroes the store. clip_mode selects wrap (0) or clip (1) at the
// right and bottom edges. Every accepted command gives exactly one response.
// A draw takes two reduction steps, an address step, then a read
// and a write-back on the store for each of the two bytes the row touches
// (a row clipped off the bottom ends after the address step, a clipped
// spill byte skips the second read and write-back); a read takes a store
// read and a capture; an unused command goes straight to the response load;
// a clear sweeps the store, writing one store byte per cycle. The load
// waits while an earlier response still sits unread in the output register.
// Ready rises again in the cycle after the load, while that response may
// still wait in the output register. After reset the same sweep runs with
// ready low; configuration transfers are taken at any time (always ready)
// and must be issued only while idle.
module xor_sprite_framebuffer #(
    parameter int DISP_WIDTH  = 64,
    parameter int DISP_HEIGHT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xsfb_req_if.sink    i_req,
    xsfb_rsp_if.source  o_rsp,
    xsfb_cfg_if.sink    i_cfg
);
    import xsfb_pkg::*;

    localparam int STORE_BYTES = (DISP_WIDTH / 8) * DISP_HEIGHT;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    t_dp_ctl          ctl;
    t_dp_stat         stat;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [7:0]       ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_rdata;

    // the clip register takes every transfer
    assign i_cfg.ready = 1'b1;

    xsfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_cmd   (i_req.cmd),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_ctl       (ctl)
    );

    xsfb_dp #(
        .DISP_WIDTH  (DISP_WIDTH),
        .DISP_HEIGHT (DISP_HEIGHT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_pos_x         (i_req.pos_x),
        .i_pos_y         (i_req.pos_y),
        .i_row_index     (i_req.row_index),
        .i_sprite_byte   (i_req.sprite_byte),
        .i_read_addr     (i_req.read_addr),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_clip_mode (i_cfg.clip_mode),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata),
        .i_rsp_ready     (o_rsp.ready),
        .o_rsp_valid     (o_rsp.valid),
        .o_rsp_collision (o_rsp.collision),
        .o_rsp_read_data (o_rsp.read_data)
    );

    // display store, one byte per entry
    xsfb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

/* rtl/xsfb_checker.sv */
// ============================================================================
// xsfb_checker: port-level checks of the XOR sprite framebuffer
// Reset behavior, one command at a time, and response hold under stall.
// ============================================================================
module xsfb_port_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic       i_rsp_collision,
    input logic [7:0] i_rsp_read_data
);

    // store sweep follows reset: no request taken
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req_ready)
        else $error("request ready right after reset");

    // no stale response survives reset
    a_reset_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    // one command in work at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous command in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_collision) && $stable(i_rsp_read_data)))
        else $error("stalled response changed");

endmodule

bind xor_sprite_framebuffer xsfb_port_checker u_xsfb_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_collision (o_rsp.collision),
    .i_rsp_read_data (o_rsp.read_data)
);
